@@ design/first_fit_allocator_with_wait_queue_top_assert.svh @@
// Assertion macros used by the allocator RTL.
`ifndef FIRST_FIT_ALLOCATOR_WITH_WAIT_QUEUE_TOP_ASSERT_SVH
`define FIRST_FIT_ALLOCATOR_WITH_WAIT_QUEUE_TOP_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define FFA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define FFA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/ffa_pkg.sv @@
`default_nettype none
package ffa_pkg;

  localparam int BLOCK_DEPTH = 64;
  localparam int PROC_DEPTH  = 64;
  localparam int WAIT_DEPTH  = 16;
  localparam int MAX_RESULTS = 17;

  localparam int OP_W   = 2;
  localparam int PID_W  = 16;
  localparam int SZ_W   = 24;
  localparam int ST_W   = 3;

  localparam int BLK_CW  = $clog2(BLOCK_DEPTH + 1);
  localparam int BLK_IW  = (BLOCK_DEPTH > 1) ? $clog2(BLOCK_DEPTH) : 1;
  localparam int PROC_CW = $clog2(PROC_DEPTH + 1);
  localparam int PROC_IW = (PROC_DEPTH > 1) ? $clog2(PROC_DEPTH) : 1;
  localparam int WAIT_CW = $clog2(WAIT_DEPTH + 1);
  localparam int WAIT_IW = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
  localparam int SC_W    = (BLK_CW > PROC_CW) ? BLK_CW : PROC_CW;
  localparam int RES_W   = $clog2(MAX_RESULTS + 1);
  localparam int TF_W    = SZ_W + BLK_CW;

  localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
  localparam logic [OP_W-1:0] OP_ADD   = 2'd2;
  localparam logic [OP_W-1:0] OP_NOP   = 2'd3;

  localparam logic [ST_W-1:0] ST_GRANTED  = 3'd0;
  localparam logic [ST_W-1:0] ST_QUEUED   = 3'd1;
  localparam logic [ST_W-1:0] ST_QFULL    = 3'd2;
  localparam logic [ST_W-1:0] ST_FREED    = 3'd3;
  localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd4;
  localparam logic [ST_W-1:0] ST_WGRANT   = 3'd5;
  localparam logic [ST_W-1:0] ST_ADDED    = 3'd6;
  localparam logic [ST_W-1:0] ST_TFULL    = 3'd7;

  typedef struct packed {
    logic            free;
    logic [SZ_W-1:0] size;
    logic [SZ_W-1:0] start;
  } blk_entry_t;

  typedef struct packed {
    logic [PID_W-1:0] owner;
    logic [SZ_W-1:0]  addr;
  } proc_entry_t;

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [PID_W-1:0] pid;
    logic [SZ_W-1:0]  addr;
    logic [SZ_W-1:0]  size;
  } result_t;

endpackage
`default_nettype wire

@@ design/ffa_if.sv @@
`default_nettype none
interface ffa_in_if;
  logic                      valid;
  logic                      ready;
  logic [ffa_pkg::OP_W-1:0]  op;
  logic [ffa_pkg::PID_W-1:0] proc_id;
  logic [ffa_pkg::SZ_W-1:0]  size;
  modport source (output valid, op, proc_id, size, input ready);
  modport sink (input valid, op, proc_id, size, output ready);
endinterface

interface ffa_out_if;
  logic                      valid;
  logic                      ready;
  logic [ffa_pkg::ST_W-1:0]  status;
  logic [ffa_pkg::PID_W-1:0] out_process_id;
  logic [ffa_pkg::SZ_W-1:0]  address;
  logic [ffa_pkg::SZ_W-1:0]  out_size;
  logic                      last;
  modport source (output valid, status, out_process_id, address, out_size, last, input ready);
  modport sink (input valid, status, out_process_id, address, out_size, last, output ready);
endinterface
`default_nettype wire

@@ design/first_fit_allocator_with_wait_queue_top.sv @@
// Channel  | Dir | Word
// in_ch    | in  | op, proc_id, size
// out_ch   | out | status, out_process_id, address, out_size, last
//
// One request at a time; in_ch.ready is high only while the sequencer is idle.
// An add appends a block entry if the table has room. An allocate scans
// block entries for the first free fit, probes process slots for a free one
// and, on a split, moves the later entries up by one. A free scans process
// slots and block entries, then for each waiter sums the free space and, if
// it suffices, runs an allocate. Reset is synchronous; a stalled output
// word holds the sequencer in its emit step.
`default_nettype none
`include "first_fit_allocator_with_wait_queue_top_assert.svh"
module first_fit_allocator_with_wait_queue_top (
  input  wire          clk,
  input  wire          rst_n,
  ffa_in_if.sink       in_ch,
  ffa_out_if.source    out_ch
);

  localparam int S_W = 5;
  localparam logic [S_W-1:0] S_IDLE   = 5'd0;
  localparam logic [S_W-1:0] S_EMIT   = 5'd1;
  localparam logic [S_W-1:0] S_FF_RD  = 5'd2;
  localparam logic [S_W-1:0] S_FF_CHK = 5'd3;
  localparam logic [S_W-1:0] S_PS     = 5'd4;
  localparam logic [S_W-1:0] S_SH_RD  = 5'd5;
  localparam logic [S_W-1:0] S_SH_WR  = 5'd6;
  localparam logic [S_W-1:0] S_SP_HI  = 5'd7;
  localparam logic [S_W-1:0] S_SP_LO  = 5'd8;
  localparam logic [S_W-1:0] S_FR_RD  = 5'd9;
  localparam logic [S_W-1:0] S_FR_CHK = 5'd10;
  localparam logic [S_W-1:0] S_FB_RD  = 5'd11;
  localparam logic [S_W-1:0] S_FB_CHK = 5'd12;
  localparam logic [S_W-1:0] S_W_TOP  = 5'd13;
  localparam logic [S_W-1:0] S_TF_RD  = 5'd14;
  localparam logic [S_W-1:0] S_TF_CHK = 5'd15;
  localparam logic [S_W-1:0] S_W_LOAD = 5'd16;

  localparam int BIW = ffa_pkg::BLK_IW;
  localparam int PIW = ffa_pkg::PROC_IW;
  localparam int WIW = ffa_pkg::WAIT_IW;
  localparam int WCW = ffa_pkg::WAIT_CW;
  localparam int SCW = ffa_pkg::SC_W;

  localparam logic [ffa_pkg::BLK_CW-1:0] BLK_FULL = ffa_pkg::BLK_CW'(ffa_pkg::BLOCK_DEPTH);
  localparam logic [ffa_pkg::RES_W-1:0] RES_CAP = ffa_pkg::RES_W'(ffa_pkg::MAX_RESULTS);

  logic [S_W-1:0] state_r, state_nxt, ret_r, ret_nxt;
  logic [SCW-1:0] idx_r, idx_nxt;
  logic mode_r, mode_nxt, last_r, last_nxt;
  logic [ffa_pkg::PID_W-1:0] pid_r, pid_nxt;
  logic [ffa_pkg::SZ_W-1:0] need_r, need_nxt, fstart_r, fstart_nxt;
  logic [ffa_pkg::SZ_W-1:0] fsize_r, fsize_nxt, paddr_r, paddr_nxt;
  logic [ffa_pkg::SZ_W-1:0] nbs_r, nbs_nxt;
  logic [BIW-1:0] fi_r, fi_nxt;
  logic [PIW-1:0] slot_r, slot_nxt;
  logic [ffa_pkg::BLK_CW-1:0] blk_cnt_r, blk_cnt_nxt;
  logic [ffa_pkg::PROC_DEPTH-1:0] active_r, active_nxt;
  logic [WIW-1:0] wq_head_r, wq_head_nxt, wq_tail;
  logic [WCW-1:0] wq_cnt_r, wq_cnt_nxt;
  logic [WCW:0] wq_sum;
  logic [ffa_pkg::RES_W-1:0] n_r, n_nxt;
  logic [ffa_pkg::TF_W-1:0] tf_r, tf_nxt;
  ffa_pkg::result_t pd_r, pd_nxt, out_r, out_nxt;
  logic out_valid_r, out_valid_nxt, out_last_r, out_last_nxt;

  ffa_pkg::blk_entry_t blk_mem [ffa_pkg::BLOCK_DEPTH];
  ffa_pkg::blk_entry_t blk_rd_r, blk_wdata;
  logic [BIW-1:0] blk_raddr, blk_waddr;
  logic blk_we;

  ffa_pkg::proc_entry_t proc_mem [ffa_pkg::PROC_DEPTH];
  ffa_pkg::proc_entry_t proc_rd_r;
  logic [PIW-1:0] proc_raddr;
  logic proc_we;

  logic [ffa_pkg::PID_W-1:0] wq_owner_r [ffa_pkg::WAIT_DEPTH];
  logic [ffa_pkg::SZ_W-1:0] wq_need_r [ffa_pkg::WAIT_DEPTH];
  logic wq_we;

  logic in_acc, out_free;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;

  assign out_ch.valid = out_valid_r;
  assign out_ch.status = out_r.status;
  assign out_ch.out_process_id = out_r.pid;
  assign out_ch.address = out_r.addr;
  assign out_ch.out_size = out_r.size;
  assign out_ch.last = out_last_r;

  assign wq_sum = {1'b0, wq_head_r} + (WCW + 1)'(wq_cnt_r);
  assign wq_tail = (wq_sum >= (WCW + 1)'(ffa_pkg::WAIT_DEPTH)) ?
                   WIW'(wq_sum - (WCW + 1)'(ffa_pkg::WAIT_DEPTH)) : WIW'(wq_sum);

  always_comb begin
    state_nxt = state_r;
    ret_nxt = ret_r;
    idx_nxt = idx_r;
    mode_nxt = mode_r;
    last_nxt = last_r;
    pid_nxt = pid_r;
    need_nxt = need_r;
    fstart_nxt = fstart_r;
    fsize_nxt = fsize_r;
    paddr_nxt = paddr_r;
    nbs_nxt = nbs_r;
    fi_nxt = fi_r;
    slot_nxt = slot_r;
    blk_cnt_nxt = blk_cnt_r;
    active_nxt = active_r;
    wq_head_nxt = wq_head_r;
    wq_cnt_nxt = wq_cnt_r;
    n_nxt = n_r;
    tf_nxt = tf_r;
    pd_nxt = pd_r;
    out_nxt = out_r;
    out_last_nxt = out_last_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    blk_raddr = idx_r[BIW-1:0];
    blk_waddr = idx_r[BIW-1:0];
    blk_wdata = blk_rd_r;
    blk_we = 1'b0;
    proc_raddr = idx_r[PIW-1:0];
    proc_we = 1'b0;
    wq_we = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          pid_nxt = in_ch.proc_id;
          need_nxt = in_ch.size;
          idx_nxt = '0;
          mode_nxt = 1'b0;
          last_nxt = 1'b1;
          ret_nxt = S_IDLE;
          case (in_ch.op)
            ffa_pkg::OP_ADD: begin
              if (blk_cnt_r >= ffa_pkg::BLK_CW'(ffa_pkg::BLOCK_DEPTH)) begin
                pd_nxt = '{ffa_pkg::ST_TFULL, in_ch.proc_id, '0, in_ch.size};
              end else begin
                blk_we = 1'b1;
                blk_waddr = blk_cnt_r[BIW-1:0];
                blk_wdata = '{1'b1, in_ch.size, nbs_r};
                blk_cnt_nxt = blk_cnt_r + 1'b1;
                nbs_nxt = nbs_r + in_ch.size;
                pd_nxt = '{ffa_pkg::ST_ADDED, in_ch.proc_id, nbs_r, in_ch.size};
              end
              state_nxt = S_EMIT;
            end
            ffa_pkg::OP_ALLOC: state_nxt = S_FF_RD;
            ffa_pkg::OP_FREE: state_nxt = S_FR_RD;
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_nxt = pd_r;
          out_last_nxt = last_r;
          state_nxt = ret_r;
        end
      end
      S_FF_RD: begin
        if (idx_r >= SCW'(blk_cnt_r)) begin
          last_nxt = 1'b1;
          ret_nxt = S_IDLE;
          state_nxt = S_EMIT;
          if (!mode_r) begin
            if (wq_cnt_r >= WCW'(ffa_pkg::WAIT_DEPTH)) begin
              pd_nxt = '{ffa_pkg::ST_QFULL, pid_r, '0, need_r};
            end else begin
              wq_we = 1'b1;
              wq_cnt_nxt = wq_cnt_r + 1'b1;
              pd_nxt = '{ffa_pkg::ST_QUEUED, pid_r, '0, need_r};
            end
          end
        end else begin
          state_nxt = S_FF_CHK;
        end
      end
      S_FF_CHK: begin
        if (blk_rd_r.free && (blk_rd_r.size >= need_r)) begin
          fi_nxt = idx_r[BIW-1:0];
          fstart_nxt = blk_rd_r.start;
          fsize_nxt = blk_rd_r.size;
          idx_nxt = '0;
          state_nxt = S_PS;
        end else begin
          idx_nxt = idx_r + 1'b1;
          state_nxt = S_FF_RD;
        end
      end
      S_PS: begin
        if (idx_r >= SCW'(ffa_pkg::PROC_DEPTH)) begin
          last_nxt = 1'b1;
          ret_nxt = S_IDLE;
          state_nxt = S_EMIT;
          if (!mode_r) begin
            pd_nxt = '{ffa_pkg::ST_TFULL, pid_r, '0, need_r};
          end
        end else if (!active_r[idx_r[PIW-1:0]]) begin
          slot_nxt = idx_r[PIW-1:0];
          if (fsize_r == need_r) begin
            state_nxt = S_SP_LO;
          end else if (blk_cnt_r >= ffa_pkg::BLK_CW'(ffa_pkg::BLOCK_DEPTH)) begin
            last_nxt = 1'b1;
            ret_nxt = S_IDLE;
            state_nxt = S_EMIT;
            if (!mode_r) begin
              pd_nxt = '{ffa_pkg::ST_TFULL, pid_r, '0, need_r};
            end
          end else begin
            idx_nxt = SCW'(blk_cnt_r);
            state_nxt = S_SH_RD;
          end
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_SH_RD: begin
        blk_raddr = BIW'(idx_r - 1'b1);
        if (idx_r > (SCW'(fi_r) + SCW'(1))) begin
          state_nxt = S_SH_WR;
        end else begin
          state_nxt = S_SP_HI;
        end
      end
      S_SH_WR: begin
        blk_we = 1'b1;
        idx_nxt = idx_r - 1'b1;
        state_nxt = S_SH_RD;
      end
      S_SP_HI: begin
        blk_we = 1'b1;
        blk_waddr = fi_r + BIW'(1);
        blk_wdata = '{1'b1, fsize_r - need_r, fstart_r + need_r};
        blk_cnt_nxt = blk_cnt_r + 1'b1;
        state_nxt = S_SP_LO;
      end
      S_SP_LO: begin
        blk_we = 1'b1;
        blk_waddr = fi_r;
        blk_wdata = '{1'b0, need_r, fstart_r};
        proc_we = 1'b1;
        active_nxt[slot_r] = 1'b1;
        state_nxt = S_EMIT;
        if (mode_r) begin
          last_nxt = 1'b0;
          ret_nxt = S_W_LOAD;
        end else begin
          pd_nxt = '{ffa_pkg::ST_GRANTED, pid_r, fstart_r, need_r};
          last_nxt = 1'b1;
          ret_nxt = S_IDLE;
        end
      end
      S_W_LOAD: begin
        pd_nxt = '{ffa_pkg::ST_WGRANT, pid_r, fstart_r, need_r};
        wq_head_nxt = (wq_head_r == WIW'(ffa_pkg::WAIT_DEPTH - 1)) ? '0 : wq_head_r + 1'b1;
        wq_cnt_nxt = wq_cnt_r - 1'b1;
        n_nxt = n_r + 1'b1;
        state_nxt = S_W_TOP;
      end
      S_W_TOP: begin
        if ((wq_cnt_r != '0) && (n_r < ffa_pkg::RES_W'(ffa_pkg::MAX_RESULTS))) begin
          pid_nxt = wq_owner_r[wq_head_r];
          need_nxt = wq_need_r[wq_head_r];
          idx_nxt = '0;
          tf_nxt = '0;
          state_nxt = S_TF_RD;
        end else begin
          last_nxt = 1'b1;
          ret_nxt = S_IDLE;
          state_nxt = S_EMIT;
        end
      end
      S_TF_RD: begin
        if (idx_r >= SCW'(blk_cnt_r)) begin
          idx_nxt = '0;
          if (tf_r < ffa_pkg::TF_W'(need_r)) begin
            last_nxt = 1'b1;
            ret_nxt = S_IDLE;
            state_nxt = S_EMIT;
          end else begin
            mode_nxt = 1'b1;
            state_nxt = S_FF_RD;
          end
        end else begin
          state_nxt = S_TF_CHK;
        end
      end
      S_TF_CHK: begin
        if (blk_rd_r.free) begin
          tf_nxt = tf_r + ffa_pkg::TF_W'(blk_rd_r.size);
        end
        idx_nxt = idx_r + 1'b1;
        state_nxt = S_TF_RD;
      end
      S_FR_RD: begin
        if (idx_r >= SCW'(ffa_pkg::PROC_DEPTH)) begin
          pd_nxt = '{ffa_pkg::ST_NOTFOUND, pid_r, '0, '0};
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_FR_CHK;
        end
      end
      S_FR_CHK: begin
        if (active_r[idx_r[PIW-1:0]] && (proc_rd_r.owner == pid_r)) begin
          active_nxt[idx_r[PIW-1:0]] = 1'b0;
          paddr_nxt = proc_rd_r.addr;
          idx_nxt = '0;
          state_nxt = S_FB_RD;
        end else begin
          idx_nxt = idx_r + 1'b1;
          state_nxt = S_FR_RD;
        end
      end
      S_FB_RD: begin
        if (idx_r >= SCW'(blk_cnt_r)) begin
          pd_nxt = '{ffa_pkg::ST_NOTFOUND, pid_r, '0, '0};
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_FB_CHK;
        end
      end
      S_FB_CHK: begin
        if (!blk_rd_r.free && (blk_rd_r.start == paddr_r)) begin
          blk_we = 1'b1;
          blk_wdata = '{1'b1, blk_rd_r.size, blk_rd_r.start};
          pd_nxt = '{ffa_pkg::ST_FREED, pid_r, blk_rd_r.start, blk_rd_r.size};
          n_nxt = ffa_pkg::RES_W'(1);
          state_nxt = S_W_TOP;
        end else begin
          idx_nxt = idx_r + 1'b1;
          state_nxt = S_FB_RD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    blk_rd_r <= blk_mem[blk_raddr];
    if (blk_we) begin
      blk_mem[blk_waddr] <= blk_wdata;
    end
  end

  always_ff @(posedge clk) begin
    proc_rd_r <= proc_mem[proc_raddr];
    if (proc_we) begin
      proc_mem[slot_r] <= '{pid_r, fstart_r};
    end
  end

  always_ff @(posedge clk) begin
    if (wq_we) begin
      wq_owner_r[wq_tail] <= pid_r;
      wq_need_r[wq_tail] <= need_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      blk_cnt_r <= '0;
      nbs_r <= '0;
      active_r <= '0;
      wq_head_r <= '0;
      wq_cnt_r <= '0;
      out_valid_r <= 1'b0;
      n_r <= '0;
    end else begin
      state_r <= state_nxt;
      blk_cnt_r <= blk_cnt_nxt;
      nbs_r <= nbs_nxt;
      active_r <= active_nxt;
      wq_head_r <= wq_head_nxt;
      wq_cnt_r <= wq_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      n_r <= n_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ret_r <= ret_nxt;
    idx_r <= idx_nxt;
    mode_r <= mode_nxt;
    last_r <= last_nxt;
    pid_r <= pid_nxt;
    need_r <= need_nxt;
    fstart_r <= fstart_nxt;
    fsize_r <= fsize_nxt;
    paddr_r <= paddr_nxt;
    fi_r <= fi_nxt;
    slot_r <= slot_nxt;
    tf_r <= tf_nxt;
    pd_r <= pd_nxt;
    out_r <= out_nxt;
    out_last_r <= out_last_nxt;
  end

  `FFA_ASSERT_NOW(a_wq_bound, 1'b1, wq_cnt_r <= WCW'(ffa_pkg::WAIT_DEPTH), "wait queue overfilled")
  `FFA_ASSERT_NOW(a_blk_bound, 1'b1, blk_cnt_r <= BLK_FULL, "block table overfilled")
  `FFA_ASSERT_NOW(a_res_cap, 1'b1, n_r <= RES_CAP, "too many results for one request")
  `FFA_ASSERT_NEXT(a_busy, in_acc && (in_ch.op != ffa_pkg::OP_NOP), state_r != S_IDLE, "dropped")
  `FFA_ASSERT_NEXT(a_hold, out_valid_r && !out_ch.ready, out_valid_r && $stable(out_r), "word lost")

endmodule
`default_nettype wire
